/* hw/rtl/texture_frame_animator_macros.svh */
// Assertion macros shared by the texture frame animator RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef TEXTURE_FRAME_ANIMATOR_MACROS_SVH
`define TEXTURE_FRAME_ANIMATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfa assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfa assertion failed");

`endif

/* hw/rtl/tfa_pkg.sv */
// Package for the texture frame animator: payload types, widths, codes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package tfa_pkg;

  localparam int POS_BITS   = 16;
  localparam int DELAY_W    = 16;
  localparam int RATE_W     = 8;
  localparam int RND_W      = 10;
  localparam int STEP_W     = DELAY_W + RATE_W;
  // Forward sum pos + step, one spare bit for the carry
  localparam int SUM_W      = ((POS_BITS > STEP_W) ? POS_BITS : STEP_W) + 1;
  // Signed working width for pos - step and the blink reflection
  localparam int XW         = SUM_W + 2;
  // Divisor holds n or 2n-1
  localparam int DVS_W      = POS_BITS + 1;
  // Divider retires this many quotient bits per cycle while stepping
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = (SUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIVD_W     = DIV_STEPS * DIV_BITS;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [RND_W-1:0] TRIGGER_LEVEL = RND_W'(985);

  // Blink modes
  localparam logic [1:0] MODE_RANDOM = 2'd0;
  localparam logic [1:0] MODE_NEVER  = 2'd2;
  localparam logic [1:0] MODE_HOLD   = 2'd3;

  // How the final position is formed
  localparam logic [1:0] KIND_PASS = 2'd0;  // settled without the divider
  localparam logic [1:0] KIND_FWD  = 2'd1;  // forward loop, pos = rem
  localparam logic [1:0] KIND_REV  = 2'd2;  // reverse loop, pos = n - rem, or 0 when rem is 0
  localparam logic [1:0] KIND_PP   = 2'd3;  // ping-pong fold over 2n-1

  typedef struct packed {
    logic [POS_BITS-1:0] frame_pos;
    logic [POS_BITS-1:0] frame_count;
    logic [DELAY_W-1:0]  advance_delay;
    logic [RATE_W-1:0]   update_rate;
    logic                blink_enable;
    logic                blink_active;
    logic                reverse_dir;
    logic [1:0]          blink_mode;
    logic [RND_W-1:0]    random_draw;
  } tfa_in_t;

  typedef struct packed {
    logic [POS_BITS-1:0] new_pos;
    logic                new_active;
    logic                new_reverse;
    logic                mode_consumed;
  } tfa_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic prep;
    logic div_step;
    logic load_out;
  } tfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
  } tfa_stat_t;

endpackage

/* hw/rtl/tfa_div.sv */
// Iterative remainder unit, DIV_BITS restoring steps per cycle while step is high.
// Depends on tfa_pkg.
`timescale 1ns / 1ps
module tfa_div
  import tfa_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic [DVS_W-1:0]  rem
);

  logic [DIVD_W-1:0] shreg;
  logic [DVS_W-1:0]  dvs;
  logic [DIVD_W-1:0] shreg_next;
  logic [DVS_W-1:0]  rem_next;

  // DIV_BITS shift-compare-subtract steps on the partial remainder
  always_comb begin
    logic [DVS_W:0] t;
    shreg_next = shreg;
    rem_next   = rem;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {rem_next, shreg_next[DIVD_W-1]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
      end
      rem_next   = t[DVS_W-1:0];
      shreg_next = {shreg_next[DIVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (step) begin
      shreg <= shreg_next;
      rem   <= rem_next;
    end
  end

endmodule

/* hw/rtl/tfa_dpath.sv */
// Datapath: input capture, step multiply, mode decode, divider, result.
// Depends on tfa_pkg and tfa_div.
`timescale 1ns / 1ps
module tfa_dpath
  import tfa_pkg::*;
(
  input  logic      clk,
  input  tfa_in_t   in_data,
  input  tfa_cmd_t  cmd,
  output tfa_stat_t stat,
  output tfa_out_t  out_data
);

  tfa_in_t             in_q;
  logic [STEP_W-1:0]   prod;
  logic [POS_BITS-1:0] n_q;

  logic [1:0]          kind;
  logic [POS_BITS-1:0] pass_pos;
  logic                act;
  logic                rev;
  logic                cons;

  logic [1:0]          kind_next;
  logic [POS_BITS-1:0] pass_pos_next;
  logic                act_next;
  logic                rev_next;
  logic [DIVD_W-1:0]   dividend;
  logic [DVS_W-1:0]    divisor;
  logic [DVS_W-1:0]    rem;

  logic [SUM_W-1:0]    sum;
  logic signed [XW-1:0] xs_add;
  logic signed [XW-1:0] xs_sub;
  logic signed [XW-1:0] n_x;
  logic signed [XW-1:0] refl;
  logic signed [XW-1:0] xpp;
  logic signed [XW-1:0] upp;
  logic [DVS_W-1:0]    period;
  logic                fire;

  tfa_out_t            res;

  // Capture request, then multiply and clamp the count
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q <= in_data;
    end
    if (cmd.mul) begin
      prod <= STEP_W'(in_q.advance_delay) * STEP_W'(in_q.update_rate);
      n_q  <= (in_q.frame_count == '0) ? POS_BITS'(1) : in_q.frame_count;
    end
  end

  assign sum    = SUM_W'(in_q.frame_pos) + SUM_W'(prod);
  assign xs_add = $signed(XW'(sum));
  assign xs_sub = $signed(XW'(in_q.frame_pos)) - $signed(XW'(prod));
  assign n_x    = $signed(XW'(n_q));
  assign refl   = (n_x <<< 1) - $signed(XW'(1)) - xs_add;
  assign xpp    = in_q.reverse_dir ? xs_sub : xs_add;
  assign upp    = (xpp < 0) ? -xpp : xpp;
  assign period = (DVS_W'(n_q) << 1) - DVS_W'(1);
  assign fire   = (in_q.blink_mode == MODE_RANDOM) ? (in_q.random_draw > TRIGGER_LEVEL)
                                                   : (in_q.blink_mode != MODE_NEVER);

  // Mode decode: settle simple cases, set up the divider for the rest
  always_comb begin
    kind_next     = KIND_PASS;
    pass_pos_next = in_q.frame_pos;
    act_next      = in_q.blink_active;
    rev_next      = in_q.reverse_dir;
    dividend      = DIVD_W'(sum);
    divisor       = DVS_W'(n_q);
    if (in_q.blink_enable) begin
      if (!in_q.blink_active) begin
        if (fire) begin
          act_next = 1'b1;
          rev_next = 1'b0;
        end
      end else if (!in_q.reverse_dir) begin
        if (xs_add >= n_x) begin
          if (in_q.blink_mode == MODE_HOLD) begin
            pass_pos_next = n_q - POS_BITS'(1);
          end else if (refl < 0) begin
            pass_pos_next = '0;
            act_next      = 1'b0;
            rev_next      = 1'b0;
          end else begin
            pass_pos_next = refl[POS_BITS-1:0];
            rev_next      = 1'b1;
          end
        end else begin
          pass_pos_next = sum[POS_BITS-1:0];
        end
      end else begin
        if (xs_sub < 0) begin
          pass_pos_next = '0;
          act_next      = 1'b0;
          rev_next      = 1'b0;
        end else begin
          pass_pos_next = xs_sub[POS_BITS-1:0];
        end
      end
    end else if (in_q.blink_active) begin
      // Ping-pong: fold |x| over the period 2n-1 when out of range
      if (xpp >= 0 && xpp < n_x) begin
        pass_pos_next = xpp[POS_BITS-1:0];
      end else begin
        kind_next = KIND_PP;
        dividend  = DIVD_W'(upp[SUM_W-1:0]);
        divisor   = period;
      end
    end else if (!in_q.reverse_dir) begin
      kind_next = KIND_FWD;
    end else begin
      if (xs_sub >= 0) begin
        pass_pos_next = xs_sub[POS_BITS-1:0];
      end else begin
        kind_next = KIND_REV;
        dividend  = DIVD_W'(-xs_sub);
      end
    end
  end

  assign stat.need_div = (kind_next != KIND_PASS);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      kind     <= kind_next;
      pass_pos <= pass_pos_next;
      act      <= act_next;
      rev      <= rev_next;
      cons     <= in_q.blink_enable;
    end
  end

  tfa_div u_div (
    .clk      (clk),
    .load     (cmd.prep),
    .step     (cmd.div_step),
    .dividend (dividend),
    .divisor  (divisor),
    .rem      (rem)
  );

  // Turn the remainder, or the settled position, into the final position
  always_comb begin
    res.new_pos       = pass_pos;
    res.new_active    = act;
    res.new_reverse   = rev;
    res.mode_consumed = cons;
    unique case (kind)
      KIND_PASS: begin
        res.new_pos = pass_pos;
      end
      KIND_FWD: begin
        res.new_pos = rem[POS_BITS-1:0];
      end
      KIND_REV: begin
        res.new_pos = (rem == '0) ? '0 : (n_q - rem[POS_BITS-1:0]);
      end
      KIND_PP: begin
        if (rem == '0) begin
          res.new_pos     = '0;
          res.new_reverse = 1'b1;
        end else if (rem < DVS_W'(n_q)) begin
          res.new_pos     = rem[POS_BITS-1:0];
          res.new_reverse = 1'b0;
        end else begin
          res.new_pos     = POS_BITS'(period - rem);
          res.new_reverse = 1'b1;
        end
      end
      default: begin
        res.new_pos = pass_pos;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= res;
    end
  end

endmodule

/* hw/rtl/tfa_ctrl.sv */
// Controller: sequences capture, multiply, decode, divide and output load.
// Depends on tfa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "texture_frame_animator_macros.svh"
module tfa_ctrl
  import tfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tfa_stat_t stat,
  output tfa_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = stat.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TFA_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || out_ready)
  `TFA_ASSERT_NEXT(a_accept_to_mul, in_valid && in_ready, state == ST_MUL)
  `TFA_ASSERT_SAME(a_div_count, state == ST_DIV, cnt <= CNT_W'(DIV_STEPS - 1))
  `TFA_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)

endmodule

/* hw/rtl/texture_frame_animator.sv */
// Each request steps through capture, multiply, decode and output load; a forward
// loop or a reverse or ping-pong wrap adds the divider iterations after decode.
// A new request is taken only once the last is in the output register; the remainder
// unit retires 4 quotient bits a cycle over a 28-bit dividend (7 iterations).
// An output register holds a result while the next request is taken.
// Reset (rst, synchronous, active high) clears the controller and output valid.
`timescale 1ns / 1ps
module texture_frame_animator
  import tfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  tfa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tfa_out_t out_data
);

  tfa_cmd_t  cmd;
  tfa_stat_t stat;

  tfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tfa_dpath u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* tb/texture_frame_animator_tb.sv */
// Self-checking testbench for texture_frame_animator: directed table, then random channel runs.
// Depends on tfa_pkg (payload types, widths, blink mode codes) and the RTL top level.
`timescale 1ns / 1ps
module texture_frame_animator_tb;
  import tfa_pkg::*;

  // Blink mode 1 fires unconditionally; the package does not name it
  localparam logic [1:0] MODE_ALWAYS = 2'd1;
  localparam int TOTAL_ITEMS = 1250;
  localparam int STRETCH     = 150;
  localparam int CHOKE_AT    = 160;
  localparam int CHOKE_LEN   = 400;

  typedef struct packed {
    tfa_in_t  req;
    logic     typed;
    tfa_out_t want;
  } frame_row_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     in_valid;
  logic     in_ready;
  tfa_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tfa_out_t out_data;

  tfa_out_t   frames_due[$];
  frame_row_t frame_table[$];
  int         items_sent = 0;
  int         err_count = 0;

  texture_frame_animator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic flag_error(input string msg);
    $display("%0t ERROR %s", $time, msg);
    err_count++;
  endtask

  // Position update of one channel, worked out on wide signed integers
  function automatic tfa_out_t next_frame(input tfa_in_t req);
    tfa_out_t res;
    longint   p, n, step, x, period, u, r;
    logic     act, rev, fire;
    p    = longint'(req.frame_pos);
    n    = (req.frame_count == '0) ? 64'sd1 : longint'(req.frame_count);
    step = longint'(req.advance_delay) * longint'(req.update_rate);
    act  = req.blink_active;
    rev  = req.reverse_dir;
    if (req.blink_enable) begin
      if (!act) begin
        // Not running yet: position is kept, trigger starts a forward run
        fire = (req.blink_mode == MODE_RANDOM) ? (req.random_draw > TRIGGER_LEVEL)
                                               : (req.blink_mode != MODE_NEVER);
        if (fire) begin
          act = 1'b1;
          rev = 1'b0;
        end
      end else if (!rev) begin
        x = p + step;
        if (x >= n) begin
          if (req.blink_mode == MODE_HOLD) begin
            x = n - 1;
          end else begin
            // one reflection off the last frame
            x = 2 * n - x - 1;
            if (x < 0) begin
              x = 0;
              act = 1'b0;
            end else begin
              rev = 1'b1;
            end
          end
        end
        p = x;
      end else begin
        x = p - step;
        if (x < 0) begin
          x = 0;
          rev = 1'b0;
          act = 1'b0;
        end
        p = x;
      end
    end else if (act) begin
      // Ping-pong: repeated reflection folds with period 2n-1
      x = rev ? p - step : p + step;
      if (x >= 0 && x < n) begin
        p = x;
      end else begin
        period = 2 * n - 1;
        u = (x < 0) ? -x : x;
        r = u % period;
        if (r == 0) begin
          p = 0;
          rev = 1'b1;
        end else if (r < n) begin
          p = r;
          rev = 1'b0;
        end else begin
          p = period - r;
          rev = 1'b1;
        end
      end
    end else if (!rev) begin
      p = (p + step) % n;
    end else begin
      x = p - step;
      if (x < 0) begin
        x = x % n;
        if (x < 0) x += n;
      end
      p = x;
    end
    res.new_pos       = p[POS_BITS-1:0];
    res.new_active    = act;
    res.new_reverse   = rev;
    res.mode_consumed = req.blink_enable;
    return res;
  endfunction

  function automatic tfa_in_t upd(input int pos, input int cnt, input int dly, input int rate,
                                  input bit en, input bit act, input bit rev,
                                  input logic [1:0] mode, input int rnd);
    tfa_in_t r;
    r.frame_pos     = POS_BITS'(pos);
    r.frame_count   = POS_BITS'(cnt);
    r.advance_delay = DELAY_W'(dly);
    r.update_rate   = RATE_W'(rate);
    r.blink_enable  = en;
    r.blink_active  = act;
    r.reverse_dir   = rev;
    r.blink_mode    = mode;
    r.random_draw   = RND_W'(rnd);
    return r;
  endfunction

  function automatic tfa_out_t outcome(input int pos, input bit act, input bit rev,
                                       input bit used);
    tfa_out_t o;
    o.new_pos       = POS_BITS'(pos);
    o.new_active    = act;
    o.new_reverse   = rev;
    o.mode_consumed = used;
    return o;
  endfunction

  // Unconstrained request, biased toward small counts so wraps happen often
  function automatic tfa_in_t random_update();
    tfa_in_t     r;
    int unsigned cnt;
    case ($urandom_range(0, 2))
      0: begin
        cnt = $urandom_range(0, 16);
      end
      1: begin
        cnt = $urandom_range(0, 1000);
      end
      default: begin
        cnt = $urandom_range(0, (1 << POS_BITS) - 1);
      end
    endcase
    r.frame_count   = POS_BITS'(cnt);
    r.frame_pos     = ($urandom_range(0, 3) != 0 && cnt > 0) ?
                      POS_BITS'($urandom_range(0, cnt - 1)) :
                      POS_BITS'($urandom_range(0, (1 << POS_BITS) - 1));
    r.advance_delay = $urandom_range(0, 1) ? DELAY_W'($urandom_range(0, 16)) :
                                             DELAY_W'($urandom_range(0, 65535));
    r.update_rate   = RATE_W'($urandom_range(0, 255));
    r.blink_enable  = 1'($urandom_range(0, 1));
    r.blink_active  = 1'($urandom_range(0, 1));
    r.reverse_dir   = 1'($urandom_range(0, 1));
    r.blink_mode    = 2'($urandom_range(0, 3));
    r.random_draw   = RND_W'($urandom_range(0, 1023));
    return r;
  endfunction

  // Wait per request on either side; every third stretch runs with no idling
  function automatic int idle_gap();
    if ((items_sent / STRETCH) % 3 == 1) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Present one request, hold it until accepted, then log its expected result
  task automatic offer_update(input tfa_in_t req, input bit typed, input tfa_out_t want);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_due.push_back(typed ? want : next_frame(req));
    items_sent++;
  endtask

  // Stimulus: reset, directed table, random channel runs, drain
  initial begin : stimulus
    tfa_in_t  chan;
    tfa_out_t step_out;
    int       run_len, n_cnt, guard;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // loops and ping-pong, including zero count and position above count
    frame_table.push_back(frame_row_t'{upd(0, 0, 0, 0, 0, 0, 0, MODE_RANDOM, 0), 1'b1,
                                       outcome(0, 0, 0, 0)});
    frame_table.push_back(frame_row_t'{upd(65535, 65535, 65535, 255, 0, 0, 0, MODE_NEVER, 1023),
                                       1'b1, outcome(0, 0, 0, 0)});
    frame_table.push_back(frame_row_t'{upd(0, 65535, 65535, 255, 0, 0, 1, MODE_HOLD, 0), 1'b0,
                                       '0});
    frame_table.push_back(frame_row_t'{upd(100, 200, 10, 3, 0, 0, 1, MODE_RANDOM, 0), 1'b1,
                                       outcome(70, 0, 1, 0)});
    frame_table.push_back(frame_row_t'{upd(500, 10, 3, 1, 0, 0, 1, MODE_RANDOM, 0), 1'b1,
                                       outcome(497, 0, 1, 0)});
    frame_table.push_back(frame_row_t'{upd(500, 10, 0, 7, 0, 0, 0, MODE_RANDOM, 0), 1'b1,
                                       outcome(0, 0, 0, 0)});
    frame_table.push_back(frame_row_t'{upd(3, 10, 2, 1, 0, 1, 0, MODE_RANDOM, 0), 1'b1,
                                       outcome(5, 1, 0, 0)});
    frame_table.push_back(frame_row_t'{upd(5, 10, 5, 2, 0, 1, 0, MODE_RANDOM, 0), 1'b0, '0});
    frame_table.push_back(frame_row_t'{upd(2, 10, 5, 1, 0, 1, 1, MODE_RANDOM, 0), 1'b0, '0});
    frame_table.push_back(frame_row_t'{upd(0, 10, 19, 1, 0, 1, 0, MODE_RANDOM, 0), 1'b0, '0});
    frame_table.push_back(frame_row_t'{upd(65535, 65535, 65535, 255, 0, 1, 1, MODE_NEVER, 0),
                                       1'b0, '0});
    frame_table.push_back(frame_row_t'{upd(0, 0, 1, 1, 0, 1, 0, MODE_RANDOM, 0), 1'b0, '0});
    // blink trigger in every mode, random draw at and around the threshold
    frame_table.push_back(frame_row_t'{upd(7, 20, 1, 1, 1, 0, 1, MODE_RANDOM, 986), 1'b1,
                                       outcome(7, 1, 0, 1)});
    frame_table.push_back(frame_row_t'{upd(7, 20, 1, 1, 1, 0, 1, MODE_RANDOM, 985), 1'b1,
                                       outcome(7, 0, 1, 1)});
    frame_table.push_back(frame_row_t'{upd(7, 20, 1, 1, 1, 0, 0, MODE_RANDOM, 1023), 1'b1,
                                       outcome(7, 1, 0, 1)});
    frame_table.push_back(frame_row_t'{upd(9, 20, 3, 3, 1, 0, 1, MODE_ALWAYS, 0), 1'b1,
                                       outcome(9, 1, 0, 1)});
    frame_table.push_back(frame_row_t'{upd(9, 20, 3, 3, 1, 0, 0, MODE_NEVER, 1000), 1'b1,
                                       outcome(9, 0, 0, 1)});
    frame_table.push_back(frame_row_t'{upd(9, 20, 3, 3, 1, 0, 1, MODE_HOLD, 0), 1'b1,
                                       outcome(9, 1, 0, 1)});
    // active blink: forward, reflect, overshoot past frame 0, hold, backward
    frame_table.push_back(frame_row_t'{upd(2, 10, 3, 1, 1, 1, 0, MODE_NEVER, 0), 1'b1,
                                       outcome(5, 1, 0, 1)});
    frame_table.push_back(frame_row_t'{upd(8, 10, 5, 1, 1, 1, 0, MODE_RANDOM, 0), 1'b0, '0});
    frame_table.push_back(frame_row_t'{upd(0, 10, 100, 1, 1, 1, 0, MODE_ALWAYS, 0), 1'b1,
                                       outcome(0, 0, 0, 1)});
    frame_table.push_back(frame_row_t'{upd(8, 10, 5, 1, 1, 1, 0, MODE_HOLD, 0), 1'b1,
                                       outcome(9, 1, 0, 1)});
    frame_table.push_back(frame_row_t'{upd(65535, 65535, 65535, 255, 1, 1, 0, MODE_HOLD, 1023),
                                       1'b1, outcome(65534, 1, 0, 1)});
    frame_table.push_back(frame_row_t'{upd(8, 10, 3, 1, 1, 1, 1, MODE_NEVER, 0), 1'b1,
                                       outcome(5, 1, 1, 1)});
    frame_table.push_back(frame_row_t'{upd(2, 10, 3, 1, 1, 1, 1, MODE_RANDOM, 0), 1'b1,
                                       outcome(0, 0, 0, 1)});

    foreach (frame_table[i])
      offer_update(frame_table[i].req, frame_table[i].typed, frame_table[i].want);

    // Random part: mostly channel runs fed back from the previous result
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        chan = random_update();
        n_cnt = $urandom_range(1, 48);
        chan.frame_count   = POS_BITS'(n_cnt);
        chan.frame_pos     = POS_BITS'($urandom_range(0, n_cnt - 1));
        chan.advance_delay = DELAY_W'($urandom_range(0, 6));
        run_len = $urandom_range(4, 30);
        for (int k = 0; k < run_len && items_sent < TOTAL_ITEMS; k++) begin
          chan.update_rate = RATE_W'($urandom_range(0, 4));
          chan.random_draw = ($urandom_range(0, 2) == 0) ? RND_W'($urandom_range(986, 1023)) :
                                                           RND_W'($urandom_range(0, 1023));
          offer_update(chan, 1'b0, '0);
          step_out = next_frame(chan);
          chan.frame_pos    = step_out.new_pos;
          chan.blink_active = step_out.new_active;
          chan.reverse_dir  = step_out.new_reverse;
          // blink run clears the global mode; sometimes it is re-armed
          if (step_out.mode_consumed)
            chan.blink_mode = $urandom_range(0, 1) ? MODE_RANDOM : 2'($urandom_range(0, 3));
        end
      end else begin
        offer_update(random_update(), 1'b0, '0);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    guard = 0;
    while (frames_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (frames_due.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", frames_due.size()));
    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, field-by-field compare
  initial begin : result_side
    int       stall;
    bit       choked;
    tfa_out_t want;
    out_ready = 1'b0;
    choked = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      stall = idle_gap();
      if (!choked && items_sent >= CHOKE_AT) begin
        choked = 1'b1;
        stall = CHOKE_LEN;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (frames_due.size() == 0) begin
        flag_error($sformatf("result with no request pending, pos=%0d", out_data.new_pos));
      end else begin
        want = frames_due.pop_front();
        if (out_data.new_pos !== want.new_pos)
          flag_error($sformatf("new_pos %0d, expected %0d", out_data.new_pos, want.new_pos));
        if (out_data.new_active !== want.new_active)
          flag_error($sformatf("new_active %b, expected %b", out_data.new_active,
                               want.new_active));
        if (out_data.new_reverse !== want.new_reverse)
          flag_error($sformatf("new_reverse %b, expected %b", out_data.new_reverse,
                               want.new_reverse));
        if (out_data.mode_consumed !== want.mode_consumed)
          flag_error($sformatf("mode_consumed %b, expected %b", out_data.mode_consumed,
                               want.mode_consumed));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/tfa_pkg.sv
hw/rtl/tfa_div.sv
hw/rtl/tfa_dpath.sv
hw/rtl/tfa_ctrl.sv
hw/rtl/texture_frame_animator.sv
tb/texture_frame_animator_tb.sv
